// ----- hdl/fba_pkg.sv -----
// Shared constants, codes and beat types of the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int MAP_BYTES  = (MAX_FRAMES + 7) / 8;
  localparam int ADDR_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int SZ_W       = $clog2(MAX_FRAMES + 1);
  localparam int GRP_W      = $clog2(MAX_FRAMES / 8 + 1);
  localparam int FRAME_W    = 20;
  localparam int OFF_W      = FRAME_W + 1;
  localparam int CNT_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int FCOUNT_RST = 4096;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [SZ_W-1:0]    size_t;
  typedef logic [GRP_W-1:0]   grp_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [OFF_W-1:0]   off_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  localparam byte_t FULL_BYTE = 8'hFF;
  localparam byte_t RES_BIT   = 8'h01;
  localparam addr_t LAST_ADDR = addr_t'(MAP_BYTES - 1);

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_MARK    = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE    = 2'd0,
    REG_COUNT   = 2'd1,
    REG_RESERVE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    cmd_t   cmd;
    frame_t frame_no;
    cnt_t   count;
  } in_item_t;

  typedef struct packed {
    frame_t  alloc_frame;
    status_t status;
  } out_item_t;

endpackage

// ----- hdl/fba_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fba_ram #(
  parameter int DEPTH  = 512,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fba_lowfree.sv -----
// Lowest clear bit of one bitmap byte, as index and as one-hot mask.
`timescale 1ns / 1ps

module fba_lowfree (
  input  fba_pkg::byte_t din,
  output logic [2:0]     idx,
  output fba_pkg::byte_t onehot
);

  always_comb begin
    idx = 3'd7;
    for (int i = fba_pkg::BYTE_W - 1; i >= 0; i--) begin
      if (!din[i]) begin
        idx = 3'(i);
      end
    end
  end

  assign onehot = fba_pkg::byte_t'(1) << idx;

endmodule

// ----- hdl/frame_bitmap_allocator.sv -----
// Top level of the frame bitmap allocator: command sequencer around the bitmap RAM.
`timescale 1ns / 1ps

// A command beat is taken when start is high and busy is low; each command gives
// exactly one result beat, shown for one cycle with out_valid, which the receiver
// must take then. After reset the bitmap RAM is swept clear, one byte a cycle, with
// busy high; configuration writes are taken at any time. Release reads the byte
// and writes it back with the frame's bit cleared; allocate reads one bitmap byte
// per cycle until it finds a byte with a free frame and sets its lowest clear bit;
// mark writes whole bytes of the run without a read and reads, then rewrites, each
// partial byte; init sweeps the RAM again and then returns its result. Out-of-range
// release and mark requests answer from S_CHECK without a RAM access. busy drops the
// cycle the result is shown, so a new command can start right behind it.

module frame_bitmap_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  fba_pkg::in_item_t                   in_data,
  output logic                                busy,
  output logic                                out_valid,
  output fba_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [fba_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_CHECK   = 7'b0000100,
    S_ALLOC   = 7'b0001000,
    S_REL_WR  = 7'b0010000,
    S_MARK    = 7'b0100000,
    S_MARK_WR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  fba_pkg::frame_t  base_r;
  fba_pkg::cnt_t    fcount_r;
  logic             reserve_r;

  fba_pkg::cmd_t    cmd_r, cmd_nxt;
  fba_pkg::off_t    off_r, off_nxt;
  fba_pkg::cnt_t    cnt_r, cnt_nxt;
  fba_pkg::size_t   size_r, size_nxt;
  fba_pkg::grp_t    scan_k_r, scan_k_nxt;
  fba_pkg::addr_t   chk_k_r, chk_k_nxt;
  logic             pend_r, pend_nxt;
  fba_pkg::size_t   cur_r, cur_nxt;
  fba_pkg::size_t   end_r, end_nxt;
  fba_pkg::byte_t   mask_r, mask_nxt;
  fba_pkg::addr_t   wa_r, wa_nxt;
  fba_pkg::addr_t   clr_addr_r, clr_addr_nxt;
  logic             init_r, init_nxt;
  logic             out_valid_r, out_valid_nxt;
  fba_pkg::out_item_t out_r, out_nxt;

  logic             ram_we;
  fba_pkg::addr_t   ram_waddr;
  fba_pkg::byte_t   ram_wdata;
  fba_pkg::addr_t   ram_raddr;
  fba_pkg::byte_t   ram_rdata;

  logic [2:0]       lf_idx;
  fba_pkg::byte_t   lf_mask;

  fba_pkg::size_t   size_clamp;
  fba_pkg::grp_t    groups;
  logic             mk_last;
  fba_pkg::byte_t   mk_lo;
  fba_pkg::byte_t   mk_hi;
  fba_pkg::byte_t   mk_mask;
  logic             mark_bad;
  logic             rel_bad;

  fba_ram #(
    .DEPTH (fba_pkg::MAP_BYTES),
    .WIDTH (fba_pkg::BYTE_W),
    .ADDR_W(fba_pkg::ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fba_lowfree u_lowfree (
    .din   (ram_rdata),
    .idx   (lf_idx),
    .onehot(lf_mask)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      fcount_r  <= fba_pkg::cnt_t'(fba_pkg::FCOUNT_RST);
      reserve_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        fba_pkg::REG_BASE:    base_r    <= cfg_wdata[fba_pkg::FRAME_W-1:0];
        fba_pkg::REG_COUNT:   fcount_r  <= cfg_wdata[fba_pkg::CNT_W-1:0];
        fba_pkg::REG_RESERVE: reserve_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign size_clamp = (32'(fcount_r) > 32'(fba_pkg::MAX_FRAMES)) ?
                      fba_pkg::size_t'(fba_pkg::MAX_FRAMES) : fba_pkg::size_t'(fcount_r);
  assign groups     = fba_pkg::grp_t'(size_r >> 3);

  assign rel_bad  = off_r >= fba_pkg::off_t'(size_r);
  assign mark_bad = off_r[fba_pkg::FRAME_W] ||
                    ((fba_pkg::off_t'(off_r[fba_pkg::FRAME_W-1:0]) + fba_pkg::off_t'(cnt_r)) >
                     fba_pkg::off_t'(size_r));

  assign mk_last = (cur_r >> 3) == (end_r >> 3);
  assign mk_lo   = fba_pkg::FULL_BYTE << cur_r[2:0];
  assign mk_hi   = mk_last ? ~(fba_pkg::FULL_BYTE << end_r[2:0]) : fba_pkg::FULL_BYTE;
  assign mk_mask = mk_lo & mk_hi;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    off_nxt       = off_r;
    cnt_nxt       = cnt_r;
    size_nxt      = size_r;
    scan_k_nxt    = scan_k_r;
    chk_k_nxt     = chk_k_r;
    pend_nxt      = pend_r;
    cur_nxt       = cur_r;
    end_nxt       = end_r;
    mask_nxt      = mask_r;
    wa_nxt        = wa_r;
    clr_addr_nxt  = clr_addr_r;
    init_nxt      = init_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = (init_r && reserve_r && (clr_addr_r == '0)) ? fba_pkg::RES_BIT : '0;
        if (clr_addr_r == fba_pkg::LAST_ADDR) begin
          state_nxt = S_IDLE;
          init_nxt  = 1'b0;
          if (init_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt.alloc_frame = '0;
            out_nxt.status      = fba_pkg::ST_DONE;
          end
        end else begin
          clr_addr_nxt = clr_addr_r + fba_pkg::addr_t'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.cmd;
          off_nxt   = {1'b0, in_data.frame_no} - {1'b0, base_r};
          cnt_nxt   = in_data.count;
          size_nxt  = size_clamp;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        unique case (cmd_r)
          fba_pkg::CMD_ALLOC: begin
            scan_k_nxt = '0;
            pend_nxt   = 1'b0;
            state_nxt  = S_ALLOC;
          end
          fba_pkg::CMD_RELEASE: begin
            if (rel_bad) begin
              out_valid_nxt       = 1'b1;
              out_nxt.alloc_frame = '0;
              out_nxt.status      = fba_pkg::ST_RANGE;
              state_nxt           = S_IDLE;
            end else begin
              ram_raddr = off_r[fba_pkg::ADDR_W+2:3];
              wa_nxt    = off_r[fba_pkg::ADDR_W+2:3];
              mask_nxt  = fba_pkg::byte_t'(1) << off_r[2:0];
              state_nxt = S_REL_WR;
            end
          end
          fba_pkg::CMD_MARK: begin
            if (mark_bad) begin
              out_valid_nxt       = 1'b1;
              out_nxt.alloc_frame = '0;
              out_nxt.status      = fba_pkg::ST_RANGE;
              state_nxt           = S_IDLE;
            end else begin
              cur_nxt   = fba_pkg::size_t'(off_r);
              end_nxt   = fba_pkg::size_t'(off_r + fba_pkg::off_t'(cnt_r));
              state_nxt = S_MARK;
            end
          end
          fba_pkg::CMD_INIT: begin
            clr_addr_nxt = '0;
            init_nxt     = 1'b1;
            state_nxt    = S_CLEAR;
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_ALLOC: begin
        if (pend_r && (ram_rdata != fba_pkg::FULL_BYTE)) begin
          ram_we              = 1'b1;
          ram_waddr           = chk_k_r;
          ram_wdata           = ram_rdata | lf_mask;
          out_valid_nxt       = 1'b1;
          out_nxt.alloc_frame = base_r + fba_pkg::frame_t'({chk_k_r, lf_idx});
          out_nxt.status      = fba_pkg::ST_DONE;
          pend_nxt            = 1'b0;
          state_nxt           = S_IDLE;
        end else if (scan_k_r < groups) begin
          ram_raddr  = scan_k_r[fba_pkg::ADDR_W-1:0];
          chk_k_nxt  = scan_k_r[fba_pkg::ADDR_W-1:0];
          pend_nxt   = 1'b1;
          scan_k_nxt = scan_k_r + fba_pkg::grp_t'(1);
        end else begin
          out_valid_nxt       = 1'b1;
          out_nxt.alloc_frame = '0;
          out_nxt.status      = fba_pkg::ST_FULL;
          pend_nxt            = 1'b0;
          state_nxt           = S_IDLE;
        end
      end

      S_REL_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = wa_r;
        ram_wdata           = ram_rdata & ~mask_r;
        out_valid_nxt       = 1'b1;
        out_nxt.alloc_frame = '0;
        out_nxt.status      = fba_pkg::ST_DONE;
        state_nxt           = S_IDLE;
      end

      S_MARK: begin
        if (cur_r >= end_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.alloc_frame = '0;
          out_nxt.status      = fba_pkg::ST_DONE;
          state_nxt           = S_IDLE;
        end else begin
          cur_nxt = mk_last ? end_r : ((cur_r | fba_pkg::size_t'(7)) + fba_pkg::size_t'(1));
          if (mk_mask == fba_pkg::FULL_BYTE) begin
            // whole byte covered: no read needed
            ram_we    = 1'b1;
            ram_waddr = cur_r[fba_pkg::ADDR_W+2:3];
            ram_wdata = fba_pkg::FULL_BYTE;
          end else begin
            ram_raddr = cur_r[fba_pkg::ADDR_W+2:3];
            wa_nxt    = cur_r[fba_pkg::ADDR_W+2:3];
            mask_nxt  = mk_mask;
            state_nxt = S_MARK_WR;
          end
        end
      end

      S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wa_r;
        ram_wdata = ram_rdata | mask_r;
        state_nxt = S_MARK;
      end

      default: begin
        clr_addr_nxt = '0;
        init_nxt     = 1'b0;
        state_nxt    = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      init_r      <= 1'b0;
      pend_r      <= 1'b0;
      scan_k_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      init_r      <= init_nxt;
      pend_r      <= pend_nxt;
      scan_k_r    <= scan_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    off_r   <= off_nxt;
    cnt_r   <= cnt_nxt;
    size_r  <= size_nxt;
    chk_k_r <= chk_k_nxt;
    cur_r   <= cur_nxt;
    end_r   <= end_nxt;
    mask_r  <= mask_nxt;
    wa_r    <= wa_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but sequencer stayed idle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("bitmap write while idle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != fba_pkg::ST_DONE)) |-> (out_data.alloc_frame == '0))
    else $error("nonzero frame on a failed command");

endmodule

// ----- dv/tb_frame_bitmap_allocator.sv -----
// Self-checking testbench of the frame bitmap allocator: directed table, then random phases.
`timescale 1ns / 1ps

module tb_frame_bitmap_allocator;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_ROWS       = 27;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 78;

  typedef logic [fba_pkg::CFG_DATA_W-1:0] cfg_word_t;

  typedef struct packed {
    fba_pkg::in_item_t  beat;
    logic               typed;
    fba_pkg::out_item_t want;
  } dir_row_t;

  localparam fba_pkg::out_item_t NONE = '{20'd0, fba_pkg::ST_DONE};

  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_ALLOC,   20'hFFFFF, 13'h1FFF}, 1'b1, '{20'd1,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_RELEASE, 20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_RELEASE, 20'd4096,  13'd0},    1'b1, '{20'd0,    fba_pkg::ST_RANGE}},
    '{'{fba_pkg::CMD_RELEASE, 20'hFFFFF, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_RANGE}},
    '{'{fba_pkg::CMD_RELEASE, 20'd4095,  13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_MARK,    20'd4090,  13'd6},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_MARK,    20'd4090,  13'd7},    1'b1, '{20'd0,    fba_pkg::ST_RANGE}},
    '{'{fba_pkg::CMD_MARK,    20'd4096,  13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_MARK,    20'd4097,  13'd0},    1'b1, '{20'd0,    fba_pkg::ST_RANGE}},
    '{'{fba_pkg::CMD_MARK,    20'h00000, 13'h1FFF}, 1'b1, '{20'd0,    fba_pkg::ST_RANGE}},
    '{'{fba_pkg::CMD_MARK,    20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_INIT,    20'hFFFFF, 13'h1FFF}, 1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd1,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_MARK,    20'd8,     13'd4088}, 1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b0, NONE},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_FULL}},
    '{'{fba_pkg::CMD_RELEASE, 20'd2048,  13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd2048, fba_pkg::ST_DONE}},
    '{'{fba_pkg::CMD_ALLOC,   20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_FULL}},
    '{'{fba_pkg::CMD_INIT,    20'h00000, 13'd0},    1'b1, '{20'd0,    fba_pkg::ST_DONE}}
  };

  localparam int PH_BASE    [NUM_PHASES] = '{0, 1048575, 1048000, 12345, 0,
                                             777, 1048560, 4096, 524288, 0};
  localparam int PH_COUNT   [NUM_PHASES] = '{4096, 4096, 100, 5, 0,
                                             8191, 13, 64, 1000, 8};
  localparam int PH_RESERVE [NUM_PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  fba_pkg::in_item_t      in_data;
  logic                   busy;
  logic                   out_valid;
  fba_pkg::out_item_t     out_data;
  logic                   cfg_we;
  logic [fba_pkg::CFG_IDX_W-1:0] cfg_idx;
  cfg_word_t              cfg_wdata;

  fba_pkg::byte_t     used_map [fba_pkg::MAP_BYTES];
  fba_pkg::frame_t    pool_base;
  fba_pkg::cnt_t      pool_count;
  logic               pool_reserve;
  fba_pkg::out_item_t pending_results [$];
  int                 mismatches;
  int                 idle_cycles;

  frame_bitmap_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pool_frames();
    return (pool_count > fba_pkg::MAX_FRAMES) ? fba_pkg::MAX_FRAMES : pool_count;
  endfunction

  task automatic calc_outcome(input fba_pkg::in_item_t it, output fba_pkg::out_item_t res);
    int unsigned sz;
    int unsigned fno;
    int unsigned cnt;
    int unsigned off;
    int unsigned k;
    int unsigned b;
    bit          found;
    sz  = pool_frames();
    fno = it.frame_no;
    cnt = it.count;
    res.alloc_frame = '0;
    res.status      = fba_pkg::ST_DONE;
    case (it.cmd)
      fba_pkg::CMD_ALLOC: begin
        res.status = fba_pkg::ST_FULL;
        found = 1'b0;
        for (k = 0; k < sz / 8 && !found; k++) begin
          if (used_map[k] != fba_pkg::FULL_BYTE) begin
            b = 0;
            while (b < 7 && used_map[k][b]) b++;
            used_map[k][b] = 1'b1;
            res.alloc_frame = fba_pkg::frame_t'(pool_base + k * 8 + b);
            res.status = fba_pkg::ST_DONE;
            found = 1'b1;
          end
        end
      end
      fba_pkg::CMD_RELEASE: begin
        if (fno < pool_base || fno - pool_base >= sz) begin
          res.status = fba_pkg::ST_RANGE;
        end else begin
          off = fno - pool_base;
          used_map[off / 8][off % 8] = 1'b0;
        end
      end
      fba_pkg::CMD_MARK: begin
        if (fno < pool_base || fno - pool_base > sz || cnt > sz - (fno - pool_base)) begin
          res.status = fba_pkg::ST_RANGE;
        end else begin
          off = fno - pool_base;
          for (k = 0; k < cnt; k++) used_map[(off + k) / 8][(off + k) % 8] = 1'b1;
        end
      end
      default: begin
        foreach (used_map[i]) used_map[i] = '0;
        if (pool_reserve) used_map[0][0] = 1'b1;
      end
    endcase
  endtask

  function automatic fba_pkg::in_item_t rand_item();
    fba_pkg::in_item_t it;
    int unsigned       sz;
    int unsigned       r;
    int unsigned       r2;
    int unsigned       idx;
    int unsigned       rem;
    sz = pool_frames();
    r  = $urandom_range(0, 99);
    r2 = $urandom_range(0, 99);
    it.frame_no = fba_pkg::frame_t'($urandom);
    it.count    = fba_pkg::cnt_t'($urandom);
    if (r < 40) begin
      it.cmd = fba_pkg::CMD_ALLOC;
    end else if (r < 65) begin
      it.cmd = fba_pkg::CMD_RELEASE;
      if (sz > 0 && r2 < 85) begin
        it.frame_no = fba_pkg::frame_t'(pool_base + $urandom_range(0, sz - 1));
      end else if (r2 < 92) begin
        it.frame_no = fba_pkg::frame_t'(pool_base + sz);
      end else if (r2 < 97) begin
        it.frame_no = fba_pkg::frame_t'(pool_base - 1);
      end
    end else if (r < 88) begin
      it.cmd = fba_pkg::CMD_MARK;
      idx = $urandom_range(0, sz);
      rem = sz - idx;
      it.frame_no = fba_pkg::frame_t'(pool_base + idx);
      if (r2 < 5) begin
        it.count = fba_pkg::cnt_t'(rem);
      end else if (r2 < 85) begin
        it.count = fba_pkg::cnt_t'($urandom_range(0, (rem < 24) ? rem : 24));
      end else if (r2 < 92) begin
        it.count = fba_pkg::cnt_t'(rem + 1 + $urandom_range(0, 7));
      end else if (r2 < 96) begin
        it.frame_no = fba_pkg::frame_t'(pool_base - 1);
        it.count    = fba_pkg::cnt_t'($urandom_range(0, 3));
      end else begin
        it.frame_no = fba_pkg::frame_t'(pool_base + sz + 1);
        it.count    = '0;
      end
    end else if (r < 90) begin
      it.cmd = fba_pkg::CMD_INIT;
    end else begin
      it.cmd = fba_pkg::cmd_t'($urandom_range(0, 2));
    end
    return it;
  endfunction

  // present one beat after a random gap and wait until it is taken
  task automatic issue(input fba_pkg::in_item_t it, input logic typed,
                       input fba_pkg::out_item_t want);
    int                 gap;
    fba_pkg::out_item_t predicted;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_data = it;
    do @(posedge clk); while (busy !== 1'b0);
    calc_outcome(it, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input int base, input int count, input int reserve);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = fba_pkg::REG_BASE;
    cfg_wdata = cfg_word_t'(base);
    pool_base = fba_pkg::frame_t'(base);
    @(negedge clk);
    cfg_idx    = fba_pkg::REG_COUNT;
    cfg_wdata  = cfg_word_t'(count);
    pool_count = fba_pkg::cnt_t'(count);
    @(negedge clk);
    cfg_idx      = fba_pkg::REG_RESERVE;
    cfg_wdata    = cfg_word_t'(reserve);
    pool_reserve = reserve[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin
    fba_pkg::out_item_t exp_beat;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: alloc_frame %0d status %0d",
               out_data.alloc_frame, out_data.status);
        mismatches++;
      end else begin
        exp_beat = pending_results.pop_front();
        if (out_data.alloc_frame !== exp_beat.alloc_frame) begin
          $error("alloc_frame: expected %0d, got %0d", exp_beat.alloc_frame,
                 out_data.alloc_frame);
          mismatches++;
        end
        if (out_data.status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, out_data.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    mismatches   = 0;
    idle_cycles  = 0;
    pool_base    = '0;
    pool_count   = fba_pkg::cnt_t'(fba_pkg::FCOUNT_RST);
    pool_reserve = 1'b1;
    foreach (used_map[i]) used_map[i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++)
      issue(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_regs(PH_BASE[p], PH_COUNT[p], PH_RESERVE[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) issue(rand_item(), 1'b0, NONE);
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
